/* rtl/fat_chain_contiguity_check_macros.svh */
// assertion macros for the cluster chain checker
// used by the checker module; no other dependencies
`ifndef FAT_CHAIN_CONTIGUITY_CHECK_MACROS_SVH
`define FAT_CHAIN_CONTIGUITY_CHECK_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define FCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fcc same-cycle check failed");

// next-cycle implication under synchronous active-low reset
`define FCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fcc next-cycle check failed");

`endif

/* rtl/fcc_pkg.sv */
// shared types, constants and the microcode table of the chain checker
// no dependencies
`default_nettype none

package fcc_pkg;

  // table store geometry
  localparam int TABLE_BYTES = 8192;
  localparam int ADDR_W      = $clog2(TABLE_BYTES);
  // byte offset of an entry: up to 2 * 0xFFFF
  localparam int OFF_W       = 17;
  localparam int COUNT_W     = 24;
  localparam int STEP_W      = 4;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // configuration register indexes
  localparam logic CFG_FAT12_MODE    = 1'b0;
  localparam logic CFG_CLUSTER_SHIFT = 1'b1;

  // table entry constants
  localparam logic [15:0] EOC_FAT12  = 16'h0FF8;
  localparam logic [15:0] EOC_FAT16  = 16'hFFF8;
  localparam logic [15:0] FAT12_MASK = 16'h0FFF;
  localparam int          SECTOR_LOG = 9;

  typedef logic [STEP_W-1:0] step_t;

  // program steps
  localparam step_t STEP_COUNT     = 4'd0;
  localparam step_t STEP_RANGE     = 4'd1;
  localparam step_t STEP_LOOP      = 4'd2;
  localparam step_t STEP_READ_HI   = 4'd3;
  localparam step_t STEP_DECODE    = 4'd4;
  localparam step_t STEP_TEST_EOC  = 4'd5;
  localparam step_t STEP_TEST_LINK = 4'd6;
  localparam step_t STEP_ADVANCE   = 4'd7;
  localparam step_t STEP_NEXT_OFF  = 4'd8;
  localparam step_t STEP_EOC_LAST  = 4'd9;
  localparam step_t STEP_FAIL      = 4'd10;
  localparam step_t STEP_PASS      = 4'd11;

  // jump conditions
  typedef enum logic [3:0] {
    COND_NONE      = 4'd0,
    COND_ALWAYS    = 4'd1,
    COND_START_LT2 = 4'd2,
    COND_COUNT_LE1 = 4'd3,
    COND_BEYOND    = 4'd4,
    COND_EOC       = 4'd5,
    COND_BAD_LINK  = 4'd6,
    COND_LAST_LINK = 4'd7,
    COND_EOC_LAST  = 4'd8
  } cond_t;

  // one control word
  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  ld_count;
    logic  ld_off;
    logic  rd_lo;
    logic  rd_hi;
    logic  lat_lo;
    logic  lat_next;
    logic  advance;
    logic  emit;
    logic  emit_val;
  } ucode_t;

  // microcode table
  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    w = '0;
    case (pc)
      STEP_COUNT: begin
        w.ld_count = 1'b1;
        w.cond     = COND_START_LT2;
        w.target   = STEP_FAIL;
      end
      STEP_RANGE: begin
        w.ld_off = 1'b1;
        w.cond   = COND_COUNT_LE1;
        w.target = STEP_PASS;
      end
      STEP_LOOP: begin
        w.rd_lo  = 1'b1;
        w.cond   = COND_BEYOND;
        w.target = STEP_PASS;
      end
      STEP_READ_HI: begin
        w.rd_hi  = 1'b1;
        w.lat_lo = 1'b1;
      end
      STEP_DECODE: begin
        w.lat_next = 1'b1;
      end
      STEP_TEST_EOC: begin
        w.cond   = COND_EOC;
        w.target = STEP_EOC_LAST;
      end
      STEP_TEST_LINK: begin
        w.cond   = COND_BAD_LINK;
        w.target = STEP_FAIL;
      end
      STEP_ADVANCE: begin
        w.advance = 1'b1;
        w.cond    = COND_LAST_LINK;
        w.target  = STEP_PASS;
      end
      STEP_NEXT_OFF: begin
        w.ld_off = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_LOOP;
      end
      STEP_EOC_LAST: begin
        w.cond   = COND_EOC_LAST;
        w.target = STEP_PASS;
      end
      STEP_PASS: begin
        w.emit     = 1'b1;
        w.emit_val = 1'b1;
      end
      default: begin
        w.emit     = 1'b1;
        w.emit_val = 1'b0;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/fat_chain_contiguity_check.sv */
// top level of the FAT12/FAT16 cluster chain contiguity checker
// uses fcc_pkg and fcc_store
`default_nettype none

// Usage
//   Requests enter on start while busy is low. A write request (in_req_type 0)
//   stores in_fat_byte at in_fat_address and gives no result;
//   busy stays low. A check request (in_req_type 1) walks the cluster chain
//   from in_start_cluster for the cluster count set by in_file_size, holding
//   busy high until the answer is out.
//   The answer appears on out_contiguous with out_valid high for one cycle,
//   the first cycle with busy low again; a new request may be given then.
//   A start below two fails and one cluster or less passes without a walk;
//   otherwise each chain link costs two reads of the table store's one read
//   port plus decode and compare steps of the microcode sequencer.
//   Configuration: cfg_ready is always high; index 0 is fat12_mode, index 1
//   is cluster_shift. Write it only while no check is in flight.
//   Reset (rst_n low, synchronous) clears busy, the result strobe and the
//   configuration. Table contents are undefined until written; no clearing
//   pass is run. The receiver cannot stall: each result shows for one cycle.

module fat_chain_contiguity_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [12:0] in_fat_address,
  input  wire logic [7:0]  in_fat_byte,
  input  wire logic [15:0] in_start_cluster,
  input  wire logic [31:0] in_file_size,
  // result channel
  output logic             out_valid,
  output logic             out_contiguous,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [2:0]  cfg_data
);

  logic                        busy_r, busy_nxt;
  fcc_pkg::step_t              pc_r, pc_nxt;
  logic [15:0]                 prev_r;
  logic [31:0]                 size_r;
  logic [fcc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [fcc_pkg::COUNT_W-1:0] i_r;
  logic [fcc_pkg::OFF_W-1:0]   off_r, off_nxt;
  logic [7:0]                  lo_r;
  logic [15:0]                 next_r, next_nxt;
  logic                        out_valid_r, out_contig_r;
  logic                        fat12_r;
  logic [2:0]                  shift_r;

  fcc_pkg::ucode_t             uw;
  logic                        take;
  logic                        accept;
  logic                        cond_hit;
  logic [4:0]                  size_sh;
  logic [31:0]                 rem_mask;
  logic [fcc_pkg::OFF_W-1:0]   off_hi;
  logic [15:0]                 raw;
  logic [15:0]                 eoc;
  logic                        st_wr_en;
  logic                        st_rd_en;
  logic [fcc_pkg::ADDR_W-1:0]  st_rd_addr;
  logic [7:0]                  st_rd_data;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_contiguous = out_contig_r;
  assign cfg_ready = 1'b1;

  // current control word
  assign uw = fcc_pkg::ucode_rom(pc_r);

  // cluster count: ceil(size / (512 << shift))
  always_comb begin
    size_sh   = 5'(fcc_pkg::SECTOR_LOG) + {2'b00, shift_r};
    rem_mask  = (32'd1 << size_sh) - 32'd1;
    count_nxt = fcc_pkg::COUNT_W'(size_r >> size_sh)
              + fcc_pkg::COUNT_W'(|(size_r & rem_mask));
  end

  // byte offset of the entry for prev_r
  always_comb begin
    if (fat12_r) begin
      off_nxt = {1'b0, prev_r} + {2'b00, prev_r[15:1]};
    end else begin
      off_nxt = {prev_r, 1'b0};
    end
    off_hi = off_r + fcc_pkg::OFF_W'(1);
  end

  // entry decode from the two bytes
  always_comb begin
    raw = {st_rd_data, lo_r};
    if (fat12_r) begin
      next_nxt = prev_r[0] ? (raw >> 4) : (raw & fcc_pkg::FAT12_MASK);
      eoc      = fcc_pkg::EOC_FAT12;
    end else begin
      next_nxt = raw;
      eoc      = fcc_pkg::EOC_FAT16;
    end
  end

  // jump condition select
  always_comb begin
    case (uw.cond)
      fcc_pkg::COND_ALWAYS:    cond_hit = 1'b1;
      fcc_pkg::COND_START_LT2: cond_hit = (prev_r < 16'd2);
      fcc_pkg::COND_COUNT_LE1: cond_hit = (count_r <= fcc_pkg::COUNT_W'(1));
      fcc_pkg::COND_BEYOND:
        cond_hit = (off_r >= fcc_pkg::OFF_W'(fcc_pkg::TABLE_BYTES - 1));
      fcc_pkg::COND_EOC:       cond_hit = (next_r >= eoc);
      fcc_pkg::COND_BAD_LINK:
        cond_hit = ({1'b0, next_r} != ({1'b0, prev_r} + 17'd1));
      fcc_pkg::COND_LAST_LINK:
        cond_hit = ((i_r + fcc_pkg::COUNT_W'(1)) == count_r);
      fcc_pkg::COND_EOC_LAST:
        cond_hit = (i_r == (count_r - fcc_pkg::COUNT_W'(1)));
      default:                 cond_hit = 1'b0;
    endcase
  end

  // sequencer next step and busy flag
  always_comb begin
    take     = accept && (in_req_type == fcc_pkg::REQ_CHECK);
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (take) begin
      busy_nxt = 1'b1;
      pc_nxt   = fcc_pkg::STEP_COUNT;
    end else if (busy_r) begin
      if (uw.emit) begin
        busy_nxt = 1'b0;
      end else if (cond_hit) begin
        pc_nxt = uw.target;
      end else begin
        pc_nxt = pc_r + fcc_pkg::step_t'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= fcc_pkg::STEP_COUNT;
      out_valid_r <= 1'b0;
      fat12_r     <= 1'b0;
      shift_r     <= 3'd0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= busy_r && uw.emit;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fcc_pkg::CFG_FAT12_MODE) begin
          fat12_r <= cfg_data[0];
        end else if (cfg_index == fcc_pkg::CFG_CLUSTER_SHIFT) begin
          shift_r <= cfg_data;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (take) begin
      prev_r <= in_start_cluster;
      size_r <= in_file_size;
    end else if (busy_r && uw.advance) begin
      prev_r <= next_r;
    end
    if (busy_r && uw.ld_count) begin
      count_r <= count_nxt;
      i_r     <= fcc_pkg::COUNT_W'(1);
    end else if (busy_r && uw.advance) begin
      i_r <= i_r + fcc_pkg::COUNT_W'(1);
    end
    if (busy_r && uw.ld_off) begin
      off_r <= off_nxt;
    end
    if (busy_r && uw.lat_lo) begin
      lo_r <= st_rd_data;
    end
    if (busy_r && uw.lat_next) begin
      next_r <= next_nxt;
    end
    if (busy_r && uw.emit) begin
      out_contig_r <= uw.emit_val;
    end
  end

  // table store ports
  assign st_wr_en   = accept && (in_req_type == fcc_pkg::REQ_WRITE)
                   && (32'(in_fat_address) < 32'(fcc_pkg::TABLE_BYTES));
  assign st_rd_en   = busy_r && (uw.rd_lo || uw.rd_hi);
  assign st_rd_addr = uw.rd_hi ? off_hi[fcc_pkg::ADDR_W-1:0]
                               : off_r[fcc_pkg::ADDR_W-1:0];

  fcc_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (fcc_pkg::ADDR_W'(in_fat_address)),
    .wr_data (in_fat_byte),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

endmodule

`default_nettype wire

/* rtl/fcc_store.sv */
// byte store that holds the allocation table
// one write port, one registered read port; uses fcc_pkg
`default_nettype none

module fcc_store (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [fcc_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]                wr_data,
  input  wire logic                      rd_en,
  input  wire logic [fcc_pkg::ADDR_W-1:0] rd_addr,
  output logic      [7:0]                rd_data
);

  logic [7:0] mem [fcc_pkg::TABLE_BYTES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/fcc_checker.sv */
// port-level checks of the chain checker's request and result timing
// uses fat_chain_contiguity_check_macros.svh; bound to the top level
`default_nettype none

`include "fat_chain_contiguity_check_macros.svh"

module fcc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_req_type,
  input wire logic out_valid
);

  // a result only follows a busy cycle
  `FCC_ASSERT_NOW(a_result_after_busy, clk, rst_n, out_valid, $past(busy))
  // a result strobe is never directly followed by another
  `FCC_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // a check request makes the block busy
  `FCC_ASSERT_NEXT(a_check_busy, clk, rst_n, start && !busy && in_req_type, busy)
  // a write request finishes at once with no result
  `FCC_ASSERT_NEXT(a_write_silent, clk, rst_n, start && !busy && !in_req_type, !busy && !out_valid)

endmodule

bind fat_chain_contiguity_check fcc_checker u_fcc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid)
);

`default_nettype wire
